// File: sv/nrp_pkg.sv
// ----------------------------------------------------------------------------
// nrp_pkg: shared types and constants of the nested region profiler
// Table and stack sizes, command and status codes, memory records and the
// request bundles that the controller sends to the two memories.
// ----------------------------------------------------------------------------
package nrp_pkg;

  // Unit table size; a power of two no larger than the 12-bit unit index space
  localparam int unsigned UNIT_COUNT = 4096;
  localparam int unsigned UNIT_W     = $clog2(UNIT_COUNT);

  // Nest stack size
  localparam int unsigned NEST_DEPTH = 16;
  localparam int unsigned NEST_AW    = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int unsigned LEVEL_W    = $clog2(NEST_DEPTH + 1);

  // Field widths of the stream payloads
  localparam int unsigned IDX_IN_W = 12;
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned HIT_W    = 32;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ROOT  = 2'd3
  } status_e;

  // Counters of one unit; hits in the lowest bits so the record is the result tdata
  typedef struct packed {
    logic [CNT_W-1:0] bytes;
    logic [CNT_W-1:0] excl;
    logic [CNT_W-1:0] incl;
    logic [HIT_W-1:0] hits;
  } unit_rec_t;

  // One open region; parent is the unit that was on top when it was pushed
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] parent;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  saved;
  } nest_ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [UNIT_W-1:0] rd_addr;
    logic              wr_en;
    logic [UNIT_W-1:0] wr_addr;
    unit_rec_t         wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic      rd_en;
    logic      push;
    logic      pop;
    nest_ent_t push_ent;
  } nest_req_t;

endpackage

// File: sv/nested_region_profiler.sv
// ----------------------------------------------------------------------------
// nested_region_profiler: hardware profiler for nested code regions
// Start, finish and read commands against a per-unit counter table and a
// stack of open regions, one result transfer per command transfer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter table to zero, one entry a cycle,
// over all 4096 entries (UNIT_COUNT); s_axis_tready_o stays low until the sweep is
// done. Commands are then handled one at a time. Both state stores are
// synchronous memories with registered read data, so each command pays for
// its reads: a read reads the table and answers; a start reads the table,
// then writes it, pushes the stack and answers; a finish reads the stack,
// then updates the finished unit and then its parent through the single
// table read and write port pair, pops and answers. An error or an unknown
// command answers directly. A result waits in the output register until taken;
// a stalled output holds the block after the command's memory updates are done.
// ----------------------------------------------------------------------------
module nested_region_profiler import nrp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [143:0] s_axis_tdata_i,  // unit_id[11:0], byte_count[75:12],
                                        // timestamp[139:76], zero pad[143:140]
  input  logic [1:0]   s_axis_tuser_i,  // command[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [223:0] m_axis_tdata_o,  // hit_count[31:0], inclusive_time[95:32],
                                        // exclusive_time[159:96], bytes_total[223:160]
  output logic [1:0]   m_axis_tuser_o   // status[1:0]
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_FIN_U = 6'b001000,
    S_FIN_P = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [UNIT_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic               out_valid_q, out_valid_d;

  cmd_e               cmd_q, cmd_d;
  logic [UNIT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]   bytes_q, bytes_d;
  logic [CNT_W-1:0]   ts_q, ts_d;
  status_e            status_q, status_d;
  unit_rec_t          res_q, res_d;
  logic [CNT_W-1:0]   elapsed_q, elapsed_d;
  unit_rec_t          urec_q, urec_d;
  unit_rec_t          out_rec_q, out_rec_d;
  status_e            out_status_q, out_status_d;

  tbl_req_t           tbl_req;
  unit_rec_t          tbl_rd;
  nest_req_t          nest_req;
  nest_ent_t          nest_rd;
  logic [LEVEL_W-1:0] level;
  logic [UNIT_W-1:0]  top_unit;

  logic               in_xfer;
  logic               out_free;
  cmd_e               in_cmd;
  logic [UNIT_W-1:0]  in_idx;
  status_e            in_status;
  unit_rec_t          parent_base;

  nrp_unit_table u_table (
    .clk_i     (clk_i),
    .req_i     (tbl_req),
    .rd_data_o (tbl_rd)
  );

  nrp_nest_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (nest_req),
    .level_o    (level),
    .top_unit_o (top_unit),
    .rd_data_o  (nest_rd)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_cmd          = cmd_e'(s_axis_tuser_i);
  assign in_idx          = UNIT_W'(s_axis_tdata_i[IDX_IN_W-1:0]);

  always_comb begin
    in_status = ST_OK;
    case (in_cmd)
      CMD_START: begin
        if (in_idx == '0) begin
          in_status = ST_ROOT;
        end else if (level == LEVEL_W'(NEST_DEPTH)) begin
          in_status = ST_FULL;
        end
      end
      CMD_FINISH: begin
        if (level == '0) begin
          in_status = ST_EMPTY;
        end
      end
      default: in_status = ST_OK;
    endcase
  end

  // a recursive region has the same unit as its parent: take the record just written
  assign parent_base = (nest_rd.parent == nest_rd.unit) ? urec_q : tbl_rd;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    bytes_d      = bytes_q;
    ts_d         = ts_q;
    status_d     = status_q;
    res_d        = res_q;
    elapsed_d    = elapsed_q;
    urec_d       = urec_q;
    out_rec_d    = out_rec_q;
    out_status_d = out_status_q;
    tbl_req      = '0;
    nest_req     = '0;

    unique case (state_q)
      S_CLEAR: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = clr_cnt_q;
        clr_cnt_d       = clr_cnt_q + 1'b1;
        if (clr_cnt_q == UNIT_W'(UNIT_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d    = in_cmd;
          idx_d    = in_idx;
          bytes_d  = s_axis_tdata_i[IDX_IN_W +: CNT_W];
          ts_d     = s_axis_tdata_i[IDX_IN_W + CNT_W +: CNT_W];
          status_d = in_status;
          res_d    = '0;
          if (in_status != ST_OK || in_cmd == CMD_NONE) begin
            state_d = S_RESP;
          end else begin
            state_d         = S_EXEC;
            tbl_req.rd_en   = (in_cmd != CMD_FINISH);
            tbl_req.rd_addr = in_idx;
            nest_req.rd_en  = (in_cmd == CMD_FINISH);
          end
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_START: begin
            tbl_req.wr_en              = 1'b1;
            tbl_req.wr_addr            = idx_q;
            tbl_req.wr_data            = tbl_rd;
            tbl_req.wr_data.bytes      = tbl_rd.bytes + bytes_q;
            nest_req.push              = 1'b1;
            nest_req.push_ent.unit     = idx_q;
            nest_req.push_ent.parent   = top_unit;
            nest_req.push_ent.start    = ts_q;
            nest_req.push_ent.saved    = tbl_rd.incl;
            state_d                    = S_RESP;
          end
          CMD_FINISH: begin
            elapsed_d       = ts_q - nest_rd.start;
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = nest_rd.unit;
            state_d         = S_FIN_U;
          end
          default: begin
            res_d   = tbl_rd;
            state_d = S_RESP;
          end
        endcase
      end
      S_FIN_U: begin
        urec_d          = tbl_rd;
        urec_d.hits     = tbl_rd.hits + 1'b1;
        urec_d.excl     = tbl_rd.excl + elapsed_q;
        urec_d.incl     = nest_rd.saved + elapsed_q;
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = nest_rd.unit;
        tbl_req.wr_data = urec_d;
        tbl_req.rd_en   = 1'b1;
        tbl_req.rd_addr = nest_rd.parent;
        state_d         = S_FIN_P;
      end
      S_FIN_P: begin
        tbl_req.wr_en        = 1'b1;
        tbl_req.wr_addr      = nest_rd.parent;
        tbl_req.wr_data      = parent_base;
        tbl_req.wr_data.excl = parent_base.excl - elapsed_q;
        nest_req.pop         = 1'b1;
        state_d              = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_rec_d    = res_q;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    bytes_q      <= bytes_d;
    ts_q         <= ts_d;
    status_q     <= status_d;
    res_q        <= res_d;
    elapsed_q    <= elapsed_d;
    urec_q       <= urec_d;
    out_rec_q    <= out_rec_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_rec_q;
  assign m_axis_tuser_o  = out_status_q;

  a_fin_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN_U |=> state_q == S_FIN_P)
    else $error("parent update did not follow unit update");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE || state_q == S_RESP |-> !tbl_req.wr_en && !nest_req.push)
    else $error("memory write outside a command step");

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("accepted command not processed");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && !out_free |=> state_q == S_RESP)
    else $error("result dropped while output stalled");

endmodule

// File: sv/nrp_unit_table.sv
// ----------------------------------------------------------------------------
// nrp_unit_table: per-unit counter memory
// One write port and one read port with registered read data. A read and a
// write to the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module nrp_unit_table import nrp_pkg::*; (
  input  logic      clk_i,
  input  tbl_req_t  req_i,
  output unit_rec_t rd_data_o
);

  unit_rec_t mem_q [UNIT_COUNT];
  unit_rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/nrp_nest_stack.sv
// ----------------------------------------------------------------------------
// nrp_nest_stack: stack of open regions
// Small synchronous memory with the fill level and the unit of the top entry.
// The read always targets the top entry; read data holds until the next read.
// ----------------------------------------------------------------------------
module nrp_nest_stack import nrp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nest_req_t          req_i,
  output logic [LEVEL_W-1:0] level_o,
  output logic [UNIT_W-1:0]  top_unit_o,
  output nest_ent_t          rd_data_o
);

  nest_ent_t          mem_q [NEST_DEPTH];
  nest_ent_t          rd_data_q;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [UNIT_W-1:0]  top_unit_q, top_unit_d;
  logic [LEVEL_W-1:0] level_m1;

  assign level_m1 = level_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[level_q[NEST_AW-1:0]] <= req_i.push_ent;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[level_m1[NEST_AW-1:0]];
    end
  end

  always_comb begin
    level_d    = level_q;
    top_unit_d = top_unit_q;
    if (req_i.push) begin
      level_d    = level_q + 1'b1;
      top_unit_d = req_i.push_ent.unit;
    end else if (req_i.pop) begin
      // the popped entry remembers which unit encloses it
      level_d    = level_m1;
      top_unit_d = rd_data_q.parent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      top_unit_q <= '0;
    end else begin
      level_q    <= level_d;
      top_unit_q <= top_unit_d;
    end
  end

  assign level_o    = level_q;
  assign top_unit_o = top_unit_q;
  assign rd_data_o  = rd_data_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_W'(NEST_DEPTH))
    else $error("nest level beyond stack depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |=> level_q == LEVEL_W'($past(level_q) + 1'b1))
    else $error("push did not advance the level");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.pop && !req_i.push |=> level_q == LEVEL_W'($past(level_q) - 1'b1))
    else $error("pop did not drop the level");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.pop |-> level_q != '0)
    else $error("pop on empty stack");

endmodule

// File: verif/tb_nested_region_profiler.sv
// ----------------------------------------------------------------------------
// tb_nested_region_profiler: self-checking bench of the nested region profiler
// A short table of directed commands covers the empty-table reads, every
// status code, recursion and a full nest stack. Random start, finish, read and
// unknown command sequences follow. A local copy of the counter table and nest stack
// predicts every result, and a scoreboard compares each returned transfer.
// Both stream sides idle in random bursts, and the receiver holds off once
// for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_nested_region_profiler;
  import nrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1620;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned STUCK_LIMIT  = 20000;
  localparam logic [63:0] CNT_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    cmd_e        cmd;
    logic [11:0] unit;
    logic [63:0] nbytes;
    logic [63:0] stamp;
  } prof_cmd_t;

  typedef struct {
    status_e   st;
    unit_rec_t rec;
  } prof_result_t;

  typedef struct {
    cmd_e        cmd;
    logic [11:0] unit;
    logic [63:0] nbytes;
    logic [63:0] stamp;
    int unsigned reps;
    bit          fixed;   // expected result is the typed status, counters zero
    status_e     st;
  } dir_row_t;

  logic         clk      = 1'b0;
  logic         rst_n    = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [143:0] s_tdata  = '0;
  logic [1:0]   s_tuser  = '0;
  logic         m_tready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [223:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  // Predicted counter table and nest stack
  bit [31:0]   unit_hits_q  [UNIT_COUNT];
  bit [63:0]   unit_incl_q  [UNIT_COUNT];
  bit [63:0]   unit_excl_q  [UNIT_COUNT];
  bit [63:0]   unit_bytes_q [UNIT_COUNT];
  bit [11:0]   stack_unit   [NEST_DEPTH];
  bit [63:0]   stack_start  [NEST_DEPTH];
  bit [63:0]   stack_saved  [NEST_DEPTH];
  int unsigned nest_depth = 0;

  prof_result_t pending_results [$];
  logic [63:0]  now_stamp       = 64'd1000;
  int unsigned  mismatch_count  = 0;
  int unsigned  results_taken   = 0;
  int unsigned  stuck_cycles    = 0;
  int unsigned  sender_idle_pct = 20;
  bit           quiet_tail      = 1'b0;
  dir_row_t     directed_rows [15];

  nested_region_profiler DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one command to the predicted state and return its result
  function automatic prof_result_t profile_update(prof_cmd_t c);
    prof_result_t r;
    int unsigned  idx;
    int unsigned  top;
    int unsigned  fin_unit;
    int unsigned  parent;
    logic [63:0]  elapsed;
    r.st  = ST_OK;
    r.rec = '0;
    idx   = int'(c.unit) % UNIT_COUNT;
    case (c.cmd)
      CMD_START: begin
        if (idx == 0) begin
          r.st = ST_ROOT;
        end else if (nest_depth >= NEST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          unit_bytes_q[idx]       += c.nbytes;
          stack_unit[nest_depth]  = idx[11:0];
          stack_start[nest_depth] = c.stamp;
          stack_saved[nest_depth] = unit_incl_q[idx];
          nest_depth++;
        end
      end
      CMD_FINISH: begin
        if (nest_depth == 0) begin
          r.st = ST_EMPTY;
        end else begin
          top      = nest_depth - 1;
          fin_unit = int'(stack_unit[top]) % UNIT_COUNT;
          parent   = (top > 0) ? int'(stack_unit[top-1]) % UNIT_COUNT : 0;
          elapsed  = c.stamp - stack_start[top];
          unit_hits_q[fin_unit] += 1;
          unit_excl_q[fin_unit] += elapsed;
          unit_incl_q[fin_unit]  = stack_saved[top] + elapsed;
          // parent loses the child's time from its exclusive share
          unit_excl_q[parent]   -= elapsed;
          nest_depth = top;
        end
      end
      CMD_READ: begin
        r.rec.hits  = unit_hits_q[idx];
        r.rec.incl  = unit_incl_q[idx];
        r.rec.excl  = unit_excl_q[idx];
        r.rec.bytes = unit_bytes_q[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic prof_cmd_t make_random_cmd(int unsigned start_pct);
    prof_cmd_t   c;
    int unsigned roll;
    c.nbytes = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                           : 64'($urandom_range(0, 4095));
    if ($urandom_range(0, 39) == 0) begin
      now_stamp = {$urandom, $urandom};  // jump anywhere, elapsed may wrap
    end else begin
      now_stamp += $urandom_range(0, 64);
    end
    c.stamp = now_stamp;
    c.unit  = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(1, 12))
                                         : 12'($urandom_range(0, 4095));
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      case ($urandom_range(0, 2))
        0: begin
          c.cmd  = CMD_START;
          c.unit = '0;
        end
        1: begin
          c.cmd  = CMD_NONE;
          c.unit = 12'($urandom_range(0, 4095));
        end
        default: c.cmd = CMD_FINISH;
      endcase
    end else if (roll < 6 + start_pct) begin
      c.cmd = CMD_START;
    end else if (roll < 6 + start_pct + (94 - start_pct) * 2 / 3) begin
      c.cmd = CMD_FINISH;
    end else begin
      c.cmd = CMD_READ;
      if ($urandom_range(0, 15) == 0) c.unit = '0;
    end
    return c;
  endfunction

  task automatic send_cmd(input prof_cmd_t c, input bit fixed, input status_e fixed_st);
    prof_result_t r;
    if (!quiet_tail && $urandom_range(1, 100) <= sender_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, c.stamp, c.nbytes, c.unit};
    s_tuser  <= c.cmd;
    do @(posedge clk); while (!s_axis_tready_o);
    r = profile_update(c);
    if (fixed) begin
      r.st  = fixed_st;
      r.rec = '0;
    end
    pending_results.push_back(r);
  endtask

  task automatic check_result();
    prof_result_t exp_r;
    unit_rec_t    got;
    status_e      got_st;
    got    = unit_rec_t'(m_axis_tdata_o);
    got_st = status_e'(m_axis_tuser_o);
    results_taken++;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: unexpected result status=%0d data=%h", got_st, got);
    end else begin
      exp_r = pending_results.pop_front();
      if (got_st !== exp_r.st || got.hits !== exp_r.rec.hits ||
          got.incl !== exp_r.rec.incl || got.excl !== exp_r.rec.excl ||
          got.bytes !== exp_r.rec.bytes) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("ERROR: result %0d mismatch", results_taken);
          $display("  status exp %0d act %0d, hits exp %h act %h",
                   exp_r.st, got_st, exp_r.rec.hits, got.hits);
          $display("  incl exp %h act %h, excl exp %h act %h",
                   exp_r.rec.incl, got.incl, exp_r.rec.excl, got.excl);
          $display("  bytes exp %h act %h", exp_r.rec.bytes, got.bytes);
        end
      end
    end
  endtask

  // Result side: random stalls, one long hold once the block has warmed up
  initial begin
    int unsigned stall_pct;
    int unsigned window;
    bit          held;
    stall_pct = 0;
    window    = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid_o && m_tready) check_result();
      window++;
      if (window == 128) begin
        window    = 0;
        stall_pct = $urandom_range(0, 1) ? 30 : 0;
      end
      if (!held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(1, 100) <= stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Covers the clearing sweep after reset and the long hold
  always @(posedge clk) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("** nested_region_profiler: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    prof_cmd_t   c;
    int unsigned start_pct;
    directed_rows = '{
      '{CMD_READ,   12'd0,   64'd0,   64'd0,   1,  1'b1, ST_OK},
      '{CMD_READ,   12'hFFF, CNT_MAX, CNT_MAX, 1,  1'b1, ST_OK},
      '{CMD_FINISH, 12'd5,   64'd9,   64'd1,   1,  1'b1, ST_EMPTY},
      '{CMD_START,  12'd0,   CNT_MAX, 64'd2,   1,  1'b1, ST_ROOT},
      '{CMD_NONE,   12'hFFF, CNT_MAX, CNT_MAX, 1,  1'b1, ST_OK},
      '{CMD_START,  12'hFFF, CNT_MAX, CNT_MAX, 1,  1'b0, ST_OK},
      '{CMD_START,  12'd1,   64'd1,   64'd10,  1,  1'b0, ST_OK},
      // recursion: same unit opened inside itself
      '{CMD_START,  12'd1,   64'd2,   64'd20,  1,  1'b0, ST_OK},
      '{CMD_FINISH, 12'd0,   64'd0,   64'd25,  1,  1'b0, ST_OK},
      '{CMD_FINISH, 12'd0,   64'd0,   64'd40,  1,  1'b0, ST_OK},
      '{CMD_READ,   12'd1,   64'd0,   64'd0,   1,  1'b0, ST_OK},
      '{CMD_START,  12'd2,   64'd7,   64'd50,  15, 1'b0, ST_OK},
      '{CMD_START,  12'd3,   64'd1,   64'd60,  1,  1'b1, ST_FULL},
      // finish stamp below its start: elapsed wraps
      '{CMD_FINISH, 12'd0,   64'd0,   64'd3,   1,  1'b0, ST_OK},
      '{CMD_READ,   12'd2,   64'd0,   64'd0,   1,  1'b0, ST_OK}
    };
    while (!rst_n) @(posedge clk);

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps) begin
        c.cmd    = directed_rows[i].cmd;
        c.unit   = directed_rows[i].unit;
        c.nbytes = directed_rows[i].nbytes;
        c.stamp  = directed_rows[i].stamp;
        send_cmd(c, directed_rows[i].fixed, directed_rows[i].st);
      end
    end

    start_pct = 40;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        start_pct       = $urandom_range(25, 60);
        sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
      end
      quiet_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      c = make_random_cmd(start_pct);
      send_cmd(c, 1'b0, ST_OK);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** nested_region_profiler: PASSED **");
    end else begin
      $display("** nested_region_profiler: FAILED **");
    end
    $finish;
  end

endmodule

// File: nested_region_profiler.f
sv/nrp_pkg.sv
sv/nrp_unit_table.sv
sv/nrp_nest_stack.sv
sv/nested_region_profiler.sv
verif/tb_nested_region_profiler.sv
